// ----- sv/regfile_and_bounded_byte_memory_macros.svh -----
// ----------------------------------------------------------------------------
// regfile_and_bounded_byte_memory assertion macros
// shared concurrent assertion forms, clocked on clk, quiet while arst_n is low
// ----------------------------------------------------------------------------
`ifndef REGFILE_AND_BOUNDED_BYTE_MEMORY_MACROS_SVH
`define REGFILE_AND_BOUNDED_BYTE_MEMORY_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define RBM_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent must hold in the cycle after the antecedent
`define RBM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- sv/rbm_pkg.sv -----
// ----------------------------------------------------------------------------
// rbm_pkg
// sizes, codes and beat types of the register file and byte memory block
// ----------------------------------------------------------------------------
package rbm_pkg;

	localparam int unsigned MEM_BYTES  = 65536;
	localparam int unsigned REG_COUNT  = 32;
	localparam int unsigned BANKS      = 4;
	localparam int unsigned BANK_DEPTH = (MEM_BYTES + BANKS - 1) / BANKS;
	localparam int unsigned ROW_W      = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
	localparam int unsigned MEM_AW     = ROW_W + 2;
	localparam int unsigned REG_IDX_W  = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;

	localparam logic [7:0] BYTE_MASK = 8'hFF;

	typedef enum logic [1:0] {
		OP_REG_RD = 2'd0,
		OP_REG_WR = 2'd1,
		OP_MEM_RD = 2'd2,
		OP_MEM_WR = 2'd3
	} op_t;

	localparam logic [1:0] SZ_BYTE = 2'd0;
	localparam logic [1:0] SZ_HALF = 2'd1;

	typedef struct packed {
		op_t         operation;
		logic [1:0]  access_width;
		logic [31:0] byte_address;
		logic [4:0]  reg_number;
		logic [31:0] write_data;
	} req_t;

	typedef struct packed {
		logic [31:0] read_data;
		logic        halt_flag;
	} rsp_t;

	// request from the top level into the banked byte memory
	typedef struct packed {
		logic              en;
		logic              wr;
		logic [MEM_AW-1:0] addr;
		logic [1:0]        size;
		logic [31:0]       data;
	} mem_req_t;

	// byte count of a size code; any other code acts as a word
	function automatic logic [2:0] num_bytes(input logic [1:0] code);
		logic [2:0] n;
		unique case (code)
			SZ_BYTE: n = 3'd1;
			SZ_HALF: n = 3'd2;
			default: n = 3'd4;
		endcase
		return n;
	endfunction

endpackage

// ----- sv/rbm_ram.sv -----
// ----------------------------------------------------------------------------
// rbm_ram
// generic simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module rbm_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  logic                                        clk,
	input  logic                                        we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                            wdata,
	input  logic                                        re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                            rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- sv/rbm_bytemem.sv -----
// ----------------------------------------------------------------------------
// rbm_bytemem
// four byte-wide banks serving unaligned little-endian accesses, cleared
// after reset by a sweep over all rows
// ----------------------------------------------------------------------------
module rbm_bytemem (
	input  logic              clk,
	input  logic              arst_n,
	input  rbm_pkg::mem_req_t req,
	output logic [31:0]       rdata,
	output logic              busy
);
	import rbm_pkg::*;

	logic             clearing_q;
	logic [ROW_W-1:0] clr_q;
	logic [1:0]       off_s1;
	logic [2:0]       nb_s1;
	logic [2:0]       nbytes;
	logic             rd_en;
	logic [7:0]       bank_rd [BANKS];

	assign nbytes = num_bytes(req.size);
	assign rd_en  = req.en & ~req.wr;
	assign busy   = clearing_q;

	for (genvar b = 0; b < BANKS; b++) begin : g_bank
		logic [1:0]       lane;
		logic [ROW_W-1:0] row;
		logic             lane_on;
		logic             we;
		logic [ROW_W-1:0] waddr;
		logic [7:0]       wdata;

		always_comb begin
			// which byte of the word lands in this bank, and on which row
			lane    = 2'(b) - req.addr[1:0];
			row     = req.addr[MEM_AW-1:2] + ROW_W'(2'(b) < req.addr[1:0]);
			lane_on = {1'b0, lane} < nbytes;
			we      = clearing_q | (req.en & req.wr & lane_on);
			waddr   = clearing_q ? clr_q : row;
			wdata   = clearing_q ? '0 : (req.data[{lane, 3'b000} +: 8] & BYTE_MASK);
		end

		rbm_ram #(
			.WIDTH(8),
			.DEPTH(BANK_DEPTH)
		) u_ram (
			.clk  (clk),
			.we   (we),
			.waddr(waddr),
			.wdata(wdata),
			.re   (rd_en),
			.raddr(row),
			.rdata(bank_rd[b])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_q      <= '0;
		end else if (clearing_q) begin
			if (clr_q == ROW_W'(BANK_DEPTH - 1)) begin
				clearing_q <= 1'b0;
			end
			clr_q <= clr_q + ROW_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			off_s1 <= req.addr[1:0];
			nb_s1  <= nbytes;
		end
	end

	// rotate bank outputs back into byte order, zero the unused bytes
	always_comb begin
		logic [1:0] idx;
		idx = '0;
		for (int i = 0; i < 4; i++) begin
			idx = off_s1 + 2'(i);
			rdata[8*i +: 8] = (3'(i) < nb_s1) ? bank_rd[idx] : 8'h00;
		end
	end

endmodule

// ----- sv/regfile_and_bounded_byte_memory.sv -----
// ----------------------------------------------------------------------------
// regfile_and_bounded_byte_memory
// register file with a hardwired zero register plus a bounds-checked,
// byte-addressed little-endian memory with a sticky halt flag
// ----------------------------------------------------------------------------
//
//  channel | handshake           | payload       | direction
//  --------+---------------------+---------------+----------
//  req     | req_valid/req_stall | rbm_pkg::req_t | in
//  rsp     | rsp_valid/rsp_stall | rbm_pkg::rsp_t | out
//
//  one beat per cycle sustained while rsp_stall is low; a result passes through
//  the ram stage (ram read at accept) and then the result register
//  after reset the byte memory is swept to zero over all BANK_DEPTH rows
//  (16384 at 64 KiB), with req_stall high the whole time
//  a stalled result holds in the output register while one more request is
//  taken into the ram stage; after that req_stall follows rsp_stall
//
module regfile_and_bounded_byte_memory (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  rbm_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output rbm_pkg::rsp_t rsp
);
	import rbm_pkg::*;

	// request decode
	logic                 accept;
	logic                 is_mem;
	logic                 addr_ok;
	logic                 mem_fail;
	logic [32:0]          end_addr;
	logic                 reg_in_range;
	logic [REG_IDX_W-1:0] reg_idx;
	logic                 reg_we;
	logic                 reg_re;

	// memories
	mem_req_t             mem_req;
	logic [31:0]          mem_rdata;
	logic                 mem_busy;
	logic [31:0]          reg_rdata;
	logic [REG_COUNT-1:0] reg_vld_q;

	// ram stage and output register
	logic                 s1_valid_q;
	logic                 rd_mem_s1;
	logic                 rd_reg_s1;
	logic                 ok_s1;
	logic                 halt_s1;
	logic                 halted_q;
	logic                 rsp_load;
	logic                 rsp_valid_q;
	rsp_t                 rsp_q;

	// handshake: the ram stage only moves when the output register frees up
	assign rsp_load  = s1_valid_q & (~rsp_valid_q | ~rsp_stall);
	assign req_stall = mem_busy | (s1_valid_q & ~rsp_load);
	assign accept    = req_valid & ~req_stall;

	// bounds check on a 33 bit sum so the top of the address space cannot wrap
	assign end_addr  = {1'b0, req.byte_address} + 33'(num_bytes(req.access_width));
	assign addr_ok   = end_addr <= 33'(MEM_BYTES);
	assign is_mem    = (req.operation == OP_MEM_RD) || (req.operation == OP_MEM_WR);
	assign mem_fail  = is_mem & ~addr_ok;

	// failed accesses never reach the memory
	assign mem_req.en   = accept & is_mem & addr_ok;
	assign mem_req.wr   = req.operation == OP_MEM_WR;
	assign mem_req.addr = req.byte_address[MEM_AW-1:0];
	assign mem_req.size = req.access_width;
	assign mem_req.data = req.write_data;

	// register zero is never written, so its valid bit stays low and it reads 0
	assign reg_idx      = req.reg_number[REG_IDX_W-1:0];
	assign reg_in_range = 6'(req.reg_number) < 6'(REG_COUNT);
	assign reg_we       = accept & (req.operation == OP_REG_WR) & reg_in_range
	                      & (req.reg_number != 5'd0);
	assign reg_re       = accept & (req.operation == OP_REG_RD);

	rbm_bytemem u_bytemem (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (mem_req),
		.rdata (mem_rdata),
		.busy  (mem_busy)
	);

	rbm_ram #(
		.WIDTH(32),
		.DEPTH(REG_COUNT)
	) u_regfile (
		.clk  (clk),
		.we   (reg_we),
		.waddr(reg_idx),
		.wdata(req.write_data),
		.re   (reg_re),
		.raddr(reg_idx),
		.rdata(reg_rdata)
	);

	// valid bits stand in for clearing the register file at reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reg_vld_q <= '0;
		end else if (reg_we) begin
			reg_vld_q[reg_idx] <= 1'b1;
		end
	end

	// sticky halt, set by any out of range memory access
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			halted_q <= 1'b0;
		end else if (accept & mem_fail) begin
			halted_q <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			s1_valid_q <= accept | (s1_valid_q & ~rsp_load);
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (~rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// ram stage side information, captured with the ram read
	always_ff @(posedge clk) begin
		if (accept) begin
			rd_mem_s1 <= req.operation == OP_MEM_RD;
			rd_reg_s1 <= req.operation == OP_REG_RD;
			ok_s1     <= is_mem ? addr_ok : (reg_in_range & reg_vld_q[reg_idx]);
			halt_s1   <= halted_q | mem_fail;
		end
	end

	// result: writes and failed reads give zero
	always_ff @(posedge clk) begin
		if (rsp_load) begin
			priority if (rd_mem_s1 & ok_s1) begin
				rsp_q.read_data <= mem_rdata;
			end else if (rd_reg_s1 & ok_s1) begin
				rsp_q.read_data <= reg_rdata;
			end else begin
				rsp_q.read_data <= '0;
			end
			rsp_q.halt_flag <= halt_s1;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

`include "regfile_and_bounded_byte_memory_macros.svh"

	`RBM_ASSERT_SAME(a_no_accept_clearing, accept, !mem_busy, "request taken during clear")
	`RBM_ASSERT_NEXT(a_halt_sticky, halted_q, halted_q, "halt flag dropped")
	`RBM_ASSERT_NEXT(a_fail_halts, accept && mem_fail, halted_q && halt_s1, "bad access not halted")
	`RBM_ASSERT_SAME(a_zero_reg, 1'b1, !reg_vld_q[0], "register zero marked written")
	`RBM_ASSERT_NEXT(a_write_zero, rsp_load && !rd_mem_s1 && !rd_reg_s1, rsp_q.read_data == 32'd0, "write beat with data")

endmodule
